FILE: hw/rtl/remote_ignition_arming_interlock_assert.svh
// Assertion macros for the arming interlock.
`ifndef REMOTE_IGNITION_ARMING_INTERLOCK_ASSERT_SVH
`define REMOTE_IGNITION_ARMING_INTERLOCK_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RRIA_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("interlock check failed");
`define RRIA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("interlock check failed");
`else
`define RRIA_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define RRIA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

FILE: hw/rtl/rria_pkg.sv
package rria_pkg;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_TICK = 2'd0;
    localparam t_cmd CMD_MSG  = 2'd1;
    localparam t_cmd CMD_HB   = 2'd2;

    typedef logic [2:0] t_kind;
    localparam t_kind MSG_CONT_OK    = 3'd1;
    localparam t_kind MSG_CONT_FAULT = 3'd2;
    localparam t_kind MSG_IGN_OK     = 3'd3;
    localparam t_kind MSG_IGN_FAIL   = 3'd4;

    typedef logic [1:0] t_led;
    localparam t_led LED_OFF    = 2'd0;
    localparam t_led LED_GREEN  = 2'd1;
    localparam t_led LED_RED    = 2'd2;
    localparam t_led LED_YELLOW = 2'd3;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DEBOUNCE = 2'd0;
    localparam t_cfg_idx CFG_ARM_HOLD = 2'd1;
    localparam t_cfg_idx CFG_LINK_DLY = 2'd2;

    localparam logic [7:0]  DEBOUNCE_RST = 8'd10;
    localparam logic [15:0] ARM_HOLD_RST = 16'd1000;
    localparam logic [15:0] LINK_DLY_RST = 16'd500;

    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] SINCE_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] arm_hold_ticks;
        logic [15:0] link_led_delay;
    } t_cfg;

    typedef struct packed {
        t_cmd  command;
        logic  arm_pressed;
        logic  ignite_pressed;
        t_kind message_kind;
    } t_item;

    typedef struct packed {
        logic hb_request;
        logic fire_request;
        logic buzzer_on;
        logic link_led;
        t_led ignite_led;
        t_led continuity_led;
    } t_result;

endpackage

FILE: hw/rtl/rria_cfg.sv
module rria_cfg
    import rria_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  t_cfg_idx    i_idx,
    input  logic [15:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.arm_hold_ticks <= ARM_HOLD_RST;
            r_cfg.link_led_delay <= LINK_DLY_RST;
        end else if (i_we) begin
            case (i_idx)
                CFG_DEBOUNCE: r_cfg.debounce_ticks <= i_data[7:0];
                CFG_ARM_HOLD: r_cfg.arm_hold_ticks <= i_data;
                CFG_LINK_DLY: r_cfg.link_led_delay <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/rria_in_stage.sv
module rria_in_stage
    import rria_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hw/rtl/rria_core.sv
module rria_core
    import rria_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic [7:0]       r_arm_sl,   n_arm_sl;
    logic [7:0]       r_ign_sl,   n_ign_sl;
    logic [CNT_W-1:0] r_held,     n_held;
    logic             r_arm_seen, n_arm_seen;
    logic             r_must_rel, n_must_rel;
    logic             r_reply,    n_reply;
    logic             r_link_up,  n_link_up;
    logic [CNT_W-1:0] r_since,    n_since;
    t_led             r_cont,     n_cont;
    t_led             r_ign,      n_ign;
    logic             r_link_led, n_link_led;
    logic             r_buzz,     n_buzz;
    logic             n_fire;
    logic             n_hb;

    logic             r_out_valid;
    t_result          r_result;
    logic             w_step;
    logic [CNT_W-1:0] w_hold;
    logic [CNT_W-1:0] w_delay;

    assign o_ready = !r_out_valid || i_ready;
    assign w_step  = i_valid && o_ready;
    assign w_hold  = {1'b0, i_cfg.arm_hold_ticks};
    assign w_delay = {1'b0, i_cfg.link_led_delay};

    always_comb begin
        n_arm_sl   = r_arm_sl;
        n_ign_sl   = r_ign_sl;
        n_held     = r_held;
        n_arm_seen = r_arm_seen;
        n_must_rel = r_must_rel;
        n_reply    = r_reply;
        n_link_up  = r_link_up;
        n_since    = r_since;
        n_cont     = r_cont;
        n_ign      = r_ign;
        n_link_led = r_link_led;
        n_buzz     = r_buzz;
        n_fire     = 1'b0;
        n_hb       = 1'b0;
        case (i_item.command)
            CMD_TICK: begin
                if (i_item.arm_pressed) n_arm_sl = i_cfg.debounce_ticks;
                if (n_arm_sl != 8'd0 && n_held <= w_hold) n_held = n_held + 1'b1;
                if (n_arm_sl != 8'd0) n_arm_sl = n_arm_sl - 1'b1;
                else n_held = '0;

                if (i_item.ignite_pressed) n_ign_sl = i_cfg.debounce_ticks;
                if (n_ign_sl != 8'd0) n_ign_sl = n_ign_sl - 1'b1;

                if (r_since > w_delay && r_reply) n_link_led = 1'b1;

                if (n_arm_sl != 8'd0) begin
                    n_arm_seen = 1'b1;
                    if (!r_must_rel && n_held == CNT_W'(1)) n_ign = LED_OFF;
                    if (r_link_up) begin
                        if (!r_must_rel) n_buzz = 1'b1;
                        if (n_held == w_hold) n_ign = LED_YELLOW;
                        if (n_ign_sl != 8'd0 && !r_must_rel && n_held > w_hold) begin
                            n_ign      = LED_YELLOW;
                            n_fire     = 1'b1;
                            n_must_rel = 1'b1;
                        end
                    end
                end else if (r_arm_seen) begin
                    if (!r_must_rel) n_ign = LED_OFF;
                    if (n_ign_sl == 8'd0) n_must_rel = 1'b0;
                    n_arm_seen = 1'b0;
                end

                if (r_since != SINCE_MAX) n_since = r_since + 1'b1;
            end
            CMD_MSG: begin
                case (i_item.message_kind)
                    MSG_CONT_OK: begin
                        n_cont    = LED_GREEN;
                        n_reply   = 1'b1;
                        n_link_up = 1'b1;
                    end
                    MSG_CONT_FAULT: begin
                        n_cont    = LED_RED;
                        n_reply   = 1'b1;
                        n_link_up = 1'b1;
                    end
                    MSG_IGN_OK:   n_ign = LED_GREEN;
                    MSG_IGN_FAIL: n_ign = LED_RED;
                    default: ;
                endcase
            end
            CMD_HB: begin
                if (!r_reply) begin
                    n_cont    = LED_YELLOW;
                    n_link_up = 1'b0;
                end
                n_reply    = 1'b0;
                n_link_led = 1'b0;
                n_since    = '0;
                n_hb       = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_sl    <= '0;
            r_ign_sl    <= '0;
            r_held      <= '0;
            r_arm_seen  <= 1'b0;
            r_must_rel  <= 1'b0;
            r_reply     <= 1'b0;
            r_link_up   <= 1'b0;
            r_since     <= '0;
            r_cont      <= LED_YELLOW;
            r_ign       <= LED_OFF;
            r_link_led  <= 1'b0;
            r_buzz      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) r_out_valid <= i_valid;
            if (w_step) begin
                r_arm_sl   <= n_arm_sl;
                r_ign_sl   <= n_ign_sl;
                r_held     <= n_held;
                r_arm_seen <= n_arm_seen;
                r_must_rel <= n_must_rel;
                r_reply    <= n_reply;
                r_link_up  <= n_link_up;
                r_since    <= n_since;
                r_cont     <= n_cont;
                r_ign      <= n_ign;
                r_link_led <= n_link_led;
                r_buzz     <= n_buzz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result.continuity_led <= n_cont;
            r_result.ignite_led     <= n_ign;
            r_result.link_led       <= n_link_led;
            r_result.buzzer_on      <= n_buzz;
            r_result.fire_request   <= n_fire;
            r_result.hb_request     <= n_hb;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

FILE: hw/rtl/remote_ignition_arming_interlock.sv
// Arming and firing interlock of a remote igniter.
// Slave stream: one beat per event. tuser holds the command (tick, message
// received, heartbeat period); tdata holds the arm and ignite button levels
// and the classified message kind. Master stream: one result beat per input
// beat with the LED levels, the buzzer level and the fire and heartbeat
// request pulses.
// An accepted input beat passes the input register, then the state update and
// result register in one pass. Throughput is one beat per cycle while the
// master takes each result; the state registers feed back through the
// combinational update.
// Config writes (debounce, arm hold, link LED delay) take effect at once and
// are expected only while no beat is in flight.
// Reset (synchronous, active low) empties both stages, restores the register
// defaults and sets the continuity LED to yellow with all else off.
// A stalled master holds the result beat; the input register takes one more
// beat only if it is empty, then tready stays low until the result is taken.
`include "remote_ignition_arming_interlock_assert.svh"

module remote_ignition_arming_interlock
    import rria_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [0] arm_pressed, [1] ignite_pressed, [4:2] message_kind, [7:5] zero
    input  logic [7:0]  i_s_tdata,
    // [1:0] command
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] continuity_led, [3:2] ignite_led, [4] link_led, [5] buzzer_on,
    // [6] fire_request, [7] heartbeat_request
    output logic [7:0]  o_m_tdata
);

    t_cfg    w_cfg;
    t_item   w_s_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_core_ready;
    t_result w_result;

    assign w_s_item.command        = i_s_tuser;
    assign w_s_item.arm_pressed    = i_s_tdata[0];
    assign w_s_item.ignite_pressed = i_s_tdata[1];
    assign w_s_item.message_kind   = i_s_tdata[4:2];

    rria_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    rria_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (w_s_item),
        .o_valid (w_item_valid),
        .i_ready (w_core_ready),
        .o_item  (w_item)
    );

    rria_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_item_valid),
        .o_ready  (w_core_ready),
        .i_item   (w_item),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    assign o_m_tdata = w_result;

    `RRIA_ASSERT_NEXT(a_in_capture, i_clk, i_rst_n, i_s_tvalid && o_s_tready, w_item_valid)
    `RRIA_ASSERT_IMPLIES(a_fire_armed, i_clk, i_rst_n, o_m_tvalid && w_result.fire_request, w_result.ignite_led == LED_YELLOW && !w_result.hb_request)
    `RRIA_ASSERT_IMPLIES(a_hb_link_off, i_clk, i_rst_n, o_m_tvalid && w_result.hb_request, !w_result.link_led)

endmodule

FILE: tb/tb_remote_ignition_arming_interlock.sv
module tb_remote_ignition_arming_interlock;
    import rria_pkg::*;

    localparam t_cmd CMD_SPARE   = 2'd3;
    localparam int   STALL_LIMIT = 2000;

    // Interlock predictor plus the queue of result beats it expects.
    class interlock_scoreboard;
        logic [7:0]  deb;
        logic [15:0] hold;
        logic [15:0] dly;
        logic [7:0]  arm_left;
        logic [7:0]  ign_left;
        logic [16:0] held;
        logic [16:0] since;
        logic        arm_seen;
        logic        must_release;
        logic        reply_seen;
        logic        link_up;
        logic        link_led;
        logic        buzz;
        t_led        cont_led;
        t_led        ign_led;
        t_result     due_q[$];
        int          errors;

        function new();
            deb          = DEBOUNCE_RST;
            hold         = ARM_HOLD_RST;
            dly          = LINK_DLY_RST;
            arm_left     = '0;
            ign_left     = '0;
            held         = '0;
            since        = '0;
            arm_seen     = 1'b0;
            must_release = 1'b0;
            reply_seen   = 1'b0;
            link_up      = 1'b0;
            link_led     = 1'b0;
            buzz         = 1'b0;
            cont_led     = LED_YELLOW;
            ign_led      = LED_OFF;
            errors       = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] val);
            case (idx)
                CFG_DEBOUNCE: deb  = val[7:0];
                CFG_ARM_HOLD: hold = val;
                CFG_LINK_DLY: dly  = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void note_beat(t_cmd cmd, logic arm, logic ign, t_kind kind);
            t_result r;
            logic    fire;
            logic    hb;
            fire = 1'b0;
            hb   = 1'b0;
            case (cmd)
                CMD_TICK: begin
                    if (arm)
                        arm_left = deb;
                    if (arm_left != 0 && held <= {1'b0, hold})
                        held++;
                    if (arm_left != 0)
                        arm_left--;
                    else
                        held = '0;
                    if (ign)
                        ign_left = deb;
                    if (ign_left != 0)
                        ign_left--;
                    if (since > {1'b0, dly} && reply_seen)
                        link_led = 1'b1;
                    if (arm_left != 0) begin
                        arm_seen = 1'b1;
                        if (!must_release && held == 17'd1)
                            ign_led = LED_OFF;
                        if (link_up) begin
                            if (!must_release)
                                buzz = 1'b1;
                            if (held == {1'b0, hold})
                                ign_led = LED_YELLOW;
                            if (ign_left != 0 && !must_release && held > {1'b0, hold}) begin
                                ign_led      = LED_YELLOW;
                                fire         = 1'b1;
                                must_release = 1'b1;
                            end
                        end
                    end else if (arm_seen) begin
                        if (!must_release)
                            ign_led = LED_OFF;
                        if (ign_left == 0)
                            must_release = 1'b0;
                        arm_seen = 1'b0;
                    end
                    if (since != SINCE_MAX)
                        since++;
                end
                CMD_MSG: begin
                    case (kind)
                        MSG_CONT_OK: begin
                            cont_led   = LED_GREEN;
                            reply_seen = 1'b1;
                            link_up    = 1'b1;
                        end
                        MSG_CONT_FAULT: begin
                            cont_led   = LED_RED;
                            reply_seen = 1'b1;
                            link_up    = 1'b1;
                        end
                        MSG_IGN_OK:   ign_led = LED_GREEN;
                        MSG_IGN_FAIL: ign_led = LED_RED;
                        default: ;
                    endcase
                end
                CMD_HB: begin
                    if (!reply_seen) begin
                        cont_led = LED_YELLOW;
                        link_up  = 1'b0;
                    end
                    reply_seen = 1'b0;
                    link_led   = 1'b0;
                    since      = '0;
                    hb         = 1'b1;
                end
                default: ;
            endcase
            r.continuity_led = cont_led;
            r.ignite_led     = ign_led;
            r.link_led       = link_led;
            r.buzzer_on      = buzz;
            r.fire_request   = fire;
            r.hb_request     = hb;
            due_q.push_back(r);
        endfunction

        function void cmp(string name, logic [1:0] want, logic [1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (due_q.size() == 0) begin
                errors++;
                $display("%0t: result beat %h with nothing expected", $time, got);
                return;
            end
            want = due_q.pop_front();
            cmp("continuity_led", want.continuity_led, got.continuity_led);
            cmp("ignite_led", want.ignite_led, got.ignite_led);
            cmp("link_led", {1'b0, want.link_led}, {1'b0, got.link_led});
            cmp("buzzer_on", {1'b0, want.buzzer_on}, {1'b0, got.buzzer_on});
            cmp("fire_request", {1'b0, want.fire_request}, {1'b0, got.fire_request});
            cmp("heartbeat_request", {1'b0, want.hb_request}, {1'b0, got.hb_request});
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    t_cfg_idx    i_cfg_idx  = CFG_DEBOUNCE;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;
    logic [1:0]  i_s_tuser  = CMD_TICK;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;

    interlock_scoreboard sb;
    int idle_pct     = 0;
    int ready_hold   = 0;
    int quiet_cycles = 0;
    int beats_sent   = 0;

    remote_ignition_arming_interlock i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    task automatic send_beat(input t_cmd cmd, input logic arm, input logic ign,
                             input t_kind kind);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = cmd;
        i_s_tdata  = {3'b000, kind, ign, arm};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sb.note_beat(cmd, arm, ign, kind);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic tick(input logic arm, input logic ign);
        send_beat(CMD_TICK, arm, ign, t_kind'($urandom));
    endtask

    task automatic msg(input t_kind kind);
        send_beat(CMD_MSG, 1'($urandom_range(1)), 1'($urandom_range(1)), kind);
    endtask

    task automatic send_heartbeat();
        send_beat(CMD_HB, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  t_kind'($urandom));
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, val);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready = 1'b0;
        end else if (ready_hold != 0) begin
            i_m_tready = 1'b0;
            ready_hold--;
        end else begin
            ready_hold = gap_len();
            i_m_tready = (ready_hold == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_beat(t_result'(o_m_tdata));
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[remote_ignition_arming_interlock] ERROR");
            $finish;
        end
    end

    initial begin
        int k;
        int deb_cur;
        int hold_cur;
        int run_len;
        int phase_end;
        logic a;
        logic g;

        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset register values
        idle_pct = 20;
        tick(1'b0, 1'b0);
        send_beat(CMD_SPARE, 1'b1, 1'b1, '1);
        send_heartbeat();
        send_heartbeat();
        tick(1'b1, 1'b1);
        for (k = 0; k < 8; k++)
            msg(t_kind'(k));

        // short hold, quick debounce, no link LED delay
        write_reg(CFG_DEBOUNCE, 16'd1);
        write_reg(CFG_ARM_HOLD, 16'd2);
        write_reg(CFG_LINK_DLY, 16'd0);
        msg(MSG_CONT_OK);
        repeat (3) tick(1'b1, 1'b0);
        tick(1'b1, 1'b1);
        tick(1'b1, 1'b1);
        repeat (2) tick(1'b0, 1'b0);
        repeat (3) tick(1'b1, 1'b1);
        msg(MSG_IGN_OK);
        msg(MSG_IGN_FAIL);
        send_heartbeat();
        send_heartbeat();
        msg(MSG_CONT_FAULT);
        tick(1'b0, 1'b0);

        // zero debounce
        write_reg(CFG_DEBOUNCE, 16'd0);
        tick(1'b1, 1'b1);
        tick(1'b0, 1'b0);

        // lower the hold below a running count
        write_reg(CFG_DEBOUNCE, 16'd8);
        write_reg(CFG_ARM_HOLD, 16'd30);
        msg(MSG_CONT_OK);
        repeat (12) tick(1'b1, 1'b0);
        write_reg(CFG_ARM_HOLD, 16'd4);
        tick(1'b1, 1'b1);
        repeat (9) tick(1'b0, 1'b0);

        // widest settings
        write_reg(CFG_DEBOUNCE, 16'd255);
        write_reg(CFG_ARM_HOLD, 16'd65535);
        write_reg(CFG_LINK_DLY, 16'd65535);
        idle_pct = 3;
        msg(MSG_CONT_OK);
        send_heartbeat();
        repeat (40) tick(1'b1, 1'b0);
        tick(1'b1, 1'b1);
        msg(MSG_CONT_OK);
        tick(1'b0, 1'b0);

        // random phases
        phase_end = beats_sent;
        while (beats_sent < phase_end + 1800) begin
            case ($urandom_range(9))
                0:       deb_cur = 1;
                1:       deb_cur = 255;
                default: deb_cur = $urandom_range(12, 1);
            endcase
            case ($urandom_range(9))
                0:       hold_cur = 2;
                1:       hold_cur = 65535;
                default: hold_cur = $urandom_range(40, 2);
            endcase
            write_reg(CFG_DEBOUNCE, 16'(deb_cur));
            write_reg(CFG_ARM_HOLD, 16'(hold_cur));
            case ($urandom_range(9))
                0:       write_reg(CFG_LINK_DLY, 16'd0);
                1:       write_reg(CFG_LINK_DLY, 16'd65535);
                default: write_reg(CFG_LINK_DLY, 16'($urandom_range(60, 0)));
            endcase
            case ($urandom_range(3))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                2:       idle_pct = 30;
                default: idle_pct = 60;
            endcase
            run_len = beats_sent + $urandom_range(250, 100);
            while (beats_sent < run_len) begin
                if ($urandom_range(9) < 6) begin
                    // arm hold sequence, ignite near its end
                    if ($urandom_range(9) < 7)
                        msg($urandom_range(1) ? MSG_CONT_OK : MSG_CONT_FAULT);
                    k = (hold_cur > 70 ? 70 : hold_cur) + $urandom_range(8);
                    while (k > 0) begin
                        a = ($urandom_range(9) != 0);
                        g = (k <= 3) ? 1'($urandom_range(1)) : ($urandom_range(15) == 0);
                        case ($urandom_range(19))
                            0:       send_heartbeat();
                            1:       msg(t_kind'($urandom_range(4)));
                            default: ;
                        endcase
                        tick(a, g);
                        k--;
                    end
                    repeat ($urandom_range(deb_cur + 3)) tick(1'b0, $urandom_range(3) == 0);
                end else begin
                    send_beat(t_cmd'($urandom_range(3)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), t_kind'($urandom_range(7)));
                end
            end
        end

        i_s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0)
            $display("[remote_ignition_arming_interlock] OK");
        else
            $display("[remote_ignition_arming_interlock] ERROR");
        $finish;
    end

endmodule

FILE: remote_ignition_arming_interlock.f
+incdir+hw/rtl
hw/rtl/rria_pkg.sv
hw/rtl/rria_cfg.sv
hw/rtl/rria_in_stage.sv
hw/rtl/rria_core.sv
hw/rtl/remote_ignition_arming_interlock.sv
tb/tb_remote_ignition_arming_interlock.sv
